/* sv/frl_pkg.sv */
// ----------------------------------------------------------------------------
// frl_pkg: shared types for the fraction reducer
// status handed from the sequencer to the stream wrapper
// ----------------------------------------------------------------------------
package frl_pkg;

	typedef struct packed {
		logic busy;   // an item is in work, input side closed
		logic done;   // result ready to move into the output register
	} core_stat_t;

endpackage

/* sv/fraction_lowest_terms.sv */
// ----------------------------------------------------------------------------
// fraction_lowest_terms: reduce an unsigned fraction to lowest terms
// stream wrapper around the gcd and division sequencer, with output register
// ----------------------------------------------------------------------------
// One transfer on the slave side carries a numerator and a denominator; one
// transfer on the master side returns both divided by their greatest common
// divisor, with m_tuser high. If either operand is zero no fraction exists:
// the result is zero over zero with m_tuser low. The block works on one item
// at a time and drops s_tready from the accepting edge until the result has
// moved into the output register. A zero operand goes straight to the
// hand-off. Otherwise a binary gcd runs one shift, swap or subtract per cycle,
// followed by two restoring divisions by the gcd and a hand-off, all through
// the one shared subtractor. The output register lets a finished result wait
// for m_tready while the next item is taken in.
module fraction_lowest_terms #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// numerator, denominator (each VALUE_WIDTH bits), zero padded to bytes
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
	// master side
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// reduced_numerator, reduced_denominator (each VALUE_WIDTH bits), zero padded
	output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
	// valid_res
	output logic [0:0]             m_tuser
);

	localparam int DataW = ((2*VALUE_WIDTH+7)/8)*8;

	frl_pkg::core_stat_t    stat;
	logic                   start;
	logic                   take;
	logic [VALUE_WIDTH-1:0] res_num;
	logic [VALUE_WIDTH-1:0] res_den;
	logic                   res_ok;

	logic                   m_tvalid_q;
	logic [VALUE_WIDTH-1:0] num_q;
	logic [VALUE_WIDTH-1:0] den_q;
	logic                   ok_q;

	// input side open only while the sequencer sits idle
	assign s_tready = ~stat.busy;
	assign start    = s_tvalid & s_tready;

	// move a finished result out when the output register is free or draining
	assign take = stat.done & (~m_tvalid_q | m_tready);

	frl_core #(
		.W (VALUE_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.num_in  (s_tdata[VALUE_WIDTH-1:0]),
		.den_in  (s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
		.take    (take),
		.stat    (stat),
		.res_num (res_num),
		.res_den (res_den),
		.res_ok  (res_ok)
	);

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			num_q <= res_num;
			den_q <= res_den;
			ok_q  <= res_ok;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = DataW'({den_q, num_q});
	assign m_tuser[0] = ok_q;

	// an accepted item closes the input side on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input side still open after a transfer");

	// a result without a fraction carries zero fields
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("invalid result with nonzero fields");

	// a valid fraction never has a zero part
	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (num_q != '0 && den_q != '0))
		else $error("valid result with a zero part");

	// a waiting result holds while the sink stalls
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

/* sv/frl_alu.sv */
// ----------------------------------------------------------------------------
// frl_alu: shared subtract and compare unit
// one subtractor, borrow and zero flags, for each compare and division step
// ----------------------------------------------------------------------------
module frl_alu #(
	parameter int WIDTH = 17
) (
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	output logic [WIDTH-1:0] diff,
	output logic             borrow,
	output logic             zero
);

	assign {borrow, diff} = {1'b0, x} - {1'b0, y};
	assign zero           = (diff == '0);

endmodule

/* sv/frl_core.sv */
// ----------------------------------------------------------------------------
// frl_core: gcd and division sequencer
// binary gcd one step per cycle, then two restoring divisions by the gcd,
// all through the one shared subtractor
// ----------------------------------------------------------------------------
module frl_core #(
	parameter int W = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           num_in,
	input  logic [W-1:0]           den_in,
	input  logic                   take,
	output frl_pkg::core_stat_t    stat,
	output logic [W-1:0]           res_num,
	output logic [W-1:0]           res_den,
	output logic                   res_ok
);

	localparam int KW = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  g_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  qn_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] cnt_q;
	logic          ok_q;

	logic [W:0]    rem_sh;
	logic [W:0]    alu_x;
	logic [W:0]    alu_y;
	logic [W:0]    alu_diff;
	logic          alu_borrow;
	logic          alu_zero;
	logic [W-1:0]  rem_nx;
	logic [W-1:0]  x_nx;

	// partial remainder with the next dividend bit shifted in
	assign rem_sh = {rem_q, x_q[W-1]};

	always_comb begin
		if (state_q == ST_GCD) begin
			alu_x = {1'b0, a_q};
			alu_y = {1'b0, b_q};
		end else begin
			alu_x = rem_sh;
			alu_y = {1'b0, g_q};
		end
	end

	frl_alu #(
		.WIDTH (W + 1)
	) u_alu (
		.x      (alu_x),
		.y      (alu_y),
		.diff   (alu_diff),
		.borrow (alu_borrow),
		.zero   (alu_zero)
	);

	// restoring division step, quotient bits enter x_q from the bottom
	assign rem_nx = alu_borrow ? rem_sh[W-1:0] : alu_diff[W-1:0];
	assign x_nx   = {x_q[W-2:0], ~alu_borrow};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			d_q     <= '0;
			g_q     <= '0;
			rem_q   <= '0;
			x_q     <= '0;
			qn_q    <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (num_in == '0 || den_in == '0) begin
							ok_q    <= 1'b0;
							qn_q    <= '0;
							x_q     <= '0;
							state_q <= ST_DONE;
						end else begin
							ok_q    <= 1'b1;
							a_q     <= num_in;
							b_q     <= den_in;
							x_q     <= num_in;
							d_q     <= den_in;
							k_q     <= '0;
							state_q <= ST_GCD;
						end
					end
				end
				ST_GCD: begin
					case ({a_q[0], b_q[0]})
						2'b00: begin
							a_q <= a_q >> 1;
							b_q <= b_q >> 1;
							k_q <= k_q + KW'(1);
						end
						2'b01: begin
							a_q <= a_q >> 1;
						end
						2'b10: begin
							b_q <= b_q >> 1;
						end
						default: begin
							if (alu_zero) begin
								// operands met: gcd is the odd part times the common twos
								g_q     <= a_q << k_q;
								rem_q   <= '0;
								cnt_q   <= KW'(W - 1);
								state_q <= ST_DIVN;
							end else if (alu_borrow) begin
								a_q <= b_q;
								b_q <= a_q;
							end else begin
								a_q <= alu_diff[W-1:0] >> 1;
							end
						end
					endcase
				end
				ST_DIVN: begin
					if (cnt_q == '0) begin
						qn_q    <= x_nx;
						x_q     <= d_q;
						rem_q   <= '0;
						cnt_q   <= KW'(W - 1);
						state_q <= ST_DIVD;
					end else begin
						x_q   <= x_nx;
						rem_q <= rem_nx;
						cnt_q <= cnt_q - KW'(1);
					end
				end
				ST_DIVD: begin
					x_q   <= x_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - KW'(1);
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign res_num   = qn_q;
	assign res_den   = x_q;
	assign res_ok    = ok_q;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for fraction_lowest_terms
// drives numerator/denominator pairs over the slave stream, predicts the
// lowest-terms fraction with a euclid loop, and checks every master transfer
// in order, with random gaps on the sender and random back-pressure
// ----------------------------------------------------------------------------
module tb;

	localparam int VW = 16;
	localparam int DW = ((2*VW+7)/8)*8;

	typedef struct {
		logic [VW-1:0] num;
		logic [VW-1:0] den;
		logic          valid;
	} reduced_t;

	// predicted results, oldest first, checked against master transfers
	class lowest_terms_board;
		reduced_t reduced_q[$];
		int       errors = 0;

		// gcd by euclid, then both operands divided by it
		function automatic reduced_t reduce_fraction(logic [VW-1:0] n, logic [VW-1:0] d);
			reduced_t      r;
			logic [VW-1:0] a;
			logic [VW-1:0] b;
			logic [VW-1:0] t;
			if (n == 0 || d == 0) begin
				r.num   = '0;
				r.den   = '0;
				r.valid = 1'b0;
				return r;
			end
			a = n;
			b = d;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			r.num   = n / a;
			r.den   = d / a;
			r.valid = 1'b1;
			return r;
		endfunction

		function void note_fraction(logic [VW-1:0] n, logic [VW-1:0] d);
			reduced_q = {reduced_q, reduce_fraction(n, d)};
		endfunction

		function void check_reduced(logic [VW-1:0] num, logic [VW-1:0] den, logic valid);
			reduced_t e;
			if (reduced_q.size() == 0) begin
				$error("result transfer with no fraction pending");
				errors++;
				return;
			end
			e = reduced_q.pop_front();
			if (num !== e.num) begin
				$error("reduced_numerator: expected %0d, actual %0d", e.num, num);
				errors++;
			end
			if (den !== e.den) begin
				$error("reduced_denominator: expected %0d, actual %0d", e.den, den);
				errors++;
			end
			if (valid !== e.valid) begin
				$error("valid_res: expected %0d, actual %0d", e.valid, valid);
				errors++;
			end
		endfunction

		function int pending();
			return reduced_q.size();
		endfunction
	endclass

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata  = '0;   // numerator, denominator
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;         // reduced_numerator, reduced_denominator
	logic [0:0]    m_tuser;         // valid_res

	// no new gaps or stalls begin on either side while calm is high
	logic calm       = 1'b0;
	int   stall_left = 0;

	lowest_terms_board fracs = new();

	fraction_lowest_terms #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// one slave transfer, now and then with a random gap in front of it
	task automatic send_fraction(input logic [VW-1:0] n, input logic [VW-1:0] d);
		if (!calm && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			// mostly short gaps, some long enough to land deep in the gcd loop
			repeat ($urandom_range(99) < 90 ? $urandom_range(1, 6) : $urandom_range(7, 120))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DW'({d, n});
		do @(posedge clk); while (!s_tready);
		fracs.note_fraction(n, d);
	endtask

	// master side: check each transfer, then pick the next tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			fracs.check_reduced(m_tdata[VW-1:0], m_tdata[2*VW-1:VW], m_tuser[0]);
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(99) < 20) begin
			m_tready <= 1'b0;
			// now and then a long stall so the output register fills up
			if ($urandom_range(99) < 10)
				stall_left = $urandom_range(10, 60);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int unsigned g;
		int unsigned a;
		int unsigned b;
		logic [VW-1:0] n;
		logic [VW-1:0] d;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero operands, extremes, coprime and common-factor pairs
		send_fraction(16'd0, 16'd0);
		send_fraction(16'd0, 16'd7);
		send_fraction(16'd9, 16'd0);
		send_fraction(16'd0, 16'hFFFF);
		send_fraction(16'hFFFF, 16'd0);
		send_fraction(16'd1, 16'd1);
		send_fraction(16'hFFFF, 16'hFFFF);
		send_fraction(16'hFFFF, 16'd1);
		send_fraction(16'd1, 16'hFFFF);
		send_fraction(16'hFFFF, 16'hFFFE);
		send_fraction(16'd65521, 16'd65519);
		send_fraction(16'h8000, 16'h8000);
		send_fraction(16'h8000, 16'h4000);
		send_fraction(16'd1, 16'h8000);
		send_fraction(16'd48, 16'd18);
		send_fraction(16'hFFFF, 16'h5555);
		send_fraction(16'hAAAA, 16'h5555);
		send_fraction(16'h5555, 16'hAAAA);
		send_fraction(16'd65535, 16'd21845);
		send_fraction(16'd12, 16'd65532);

		// random: full range, small values, built-in common factors, powers of two, one zero operand, small numerators
		for (int i = 0; i < 1030; i++) begin
			calm <= (i >= 400 && i < 550);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = 16'($urandom);
					d = 16'($urandom);
				end
				3: begin
					n = 16'($urandom_range(0, 20));
					d = 16'($urandom_range(0, 20));
				end
				4, 5, 6: begin
					g = $urandom_range(1, 4095);
					a = $urandom_range(1, 65535 / g);
					b = $urandom_range(1, 65535 / g);
					n = 16'(a * g);
					d = 16'(b * g);
				end
				7: begin
					g = 1 << $urandom_range(0, 15);
					n = 16'(g * $urandom_range(1, 65535 / g));
					d = 16'(1 << $urandom_range(0, 15));
				end
				8: begin
					// one operand zero
					n = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
					d = (n == 0) ? 16'($urandom) : 16'd0;
				end
				default: begin
					n = 16'($urandom_range(1, 255));
					d = 16'($urandom);
				end
			endcase
			send_fraction(n, d);
		end
		s_tvalid <= 1'b0;
		calm     <= 1'b0;

		while (fracs.pending() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (fracs.errors == 0 && fracs.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
